FILE: src/ide_pkg.sv
// ----------------------------------------------------------------------------
// ide_pkg
// Shared types, codes and sizes of the Ising diagonal energy scaler.
// ----------------------------------------------------------------------------
package ide_pkg;

    localparam int MAX_SPINS = 16;
    localparam int SPIN_W    = $clog2(MAX_SPINS);
    localparam int CNT_W     = $clog2(MAX_SPINS + 1);
    localparam int CPL_DEPTH = MAX_SPINS * MAX_SPINS;
    localparam int CPL_AW    = $clog2(CPL_DEPTH);
    localparam int NUM_TERMS = MAX_SPINS * (MAX_SPINS + 1) / 2;

    // Fixed field widths.
    localparam int COEF_W    = 16;
    localparam int SCALE_W   = 16;
    localparam int SPINS_W   = 5;
    localparam int STATE_W   = 16;
    localparam int AMP_W     = 16;
    localparam int ENERGY_W  = 24;
    localparam int OUT_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // Datapath widths.
    localparam int ACC_W     = COEF_W + 1 + $clog2(NUM_TERMS);
    localparam int SCL_W     = ACC_W + SCALE_W + 1;
    localparam int PRD_W     = AMP_W + ENERGY_W;

    localparam int SCALE_RESET = 32768;
    localparam int SPINS_RESET = 16;

    // Command codes.
    localparam logic [1:0] CMD_LOAD_FIELD = 2'd0;
    localparam logic [1:0] CMD_LOAD_CPL   = 2'd1;
    localparam logic [1:0] CMD_EVAL       = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_S = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPINS   = 1'd1;

    typedef struct packed {
        logic [1:0]                cmd;
        logic [STATE_W-1:0]        where_index;
        logic signed [COEF_W-1:0]  coeff_value;
        logic signed [AMP_W-1:0]   amp_re;
        logic signed [AMP_W-1:0]   amp_im;
    } item_t;

    typedef struct packed {
        logic signed [ENERGY_W-1:0] state_energy;
        logic signed [OUT_W-1:0]    out_re;
        logic signed [OUT_W-1:0]    out_im;
        logic                       saturated;
    } result_t;

    typedef struct packed {
        logic                     fld_we;
        logic [SPIN_W-1:0]        fld_waddr;
        logic                     cpl_we;
        logic [CPL_AW-1:0]        cpl_waddr;
        logic signed [COEF_W-1:0] wdata;
        logic [SPIN_W-1:0]        fld_raddr;
        logic [CPL_AW-1:0]        cpl_raddr;
    } mem_ctrl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_SCALE,
        ST_ENERGY,
        ST_PROD,
        ST_FINISH
    } state_t;

endpackage

FILE: src/ide_coef_mem.sv
// ----------------------------------------------------------------------------
// ide_coef_mem
// Field and coupling coefficient memories, one write and one registered read
// port each.
// ----------------------------------------------------------------------------
module ide_coef_mem
    import ide_pkg::*;
(
    input  logic                     clk,
    input  mem_ctrl_t                ctrl,
    output logic signed [COEF_W-1:0] fld_rdata,
    output logic signed [COEF_W-1:0] cpl_rdata
);

    logic signed [COEF_W-1:0] fld_mem [MAX_SPINS];
    logic signed [COEF_W-1:0] cpl_mem [CPL_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctrl.fld_we)
        begin
            fld_mem[ctrl.fld_waddr] <= ctrl.wdata;
        end
        fld_rdata <= fld_mem[ctrl.fld_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cpl_we)
        begin
            cpl_mem[ctrl.cpl_waddr] <= ctrl.wdata;
        end
        cpl_rdata <= cpl_mem[ctrl.cpl_raddr];
    end

endmodule

FILE: src/ising_diagonal_energy_scaler.sv
// ----------------------------------------------------------------------------
// ising_diagonal_energy_scaler
// Diagonal Ising energy of one basis state, scaled by s, times the amplitude.
// ----------------------------------------------------------------------------
//  channel   signals                              carries
//  item      item_valid, item_ready, item         load or evaluate command word
//  result    result_valid, result_ready, result   energy, amplitude product, flag
//  cfg       cfg_valid, cfg_ready, cfg_index,     scale_s (0), spins_in_use (1)
//            cfg_data
//
// An evaluate walks the coefficient memories one coefficient a cycle: with n
// spins it reads n*(n+1)/2 terms, then drains, scales, rounds, multiplies and
// loads the result, and returns to idle to take the next word. A load word is
// written to its memory as it is taken in the idle state.
// After reset a clearing pass zeroes the memories with item_ready low. The
// result register frees the input side: a new word is taken while a result
// waits, and only the final write stalls on result_ready.
// ----------------------------------------------------------------------------
module ising_diagonal_energy_scaler
    import ide_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic [SCALE_W-1:0] scale_s_reg;
    logic [SPINS_W-1:0] spins_reg;

    logic [CPL_AW-1:0]  clr_cnt_reg;
    logic [SPIN_W-1:0]  i_reg;
    logic [SPIN_W-1:0]  j_reg;
    logic [SPIN_W-1:0]  n_last_reg;
    logic [STATE_W-1:0] bits_reg;
    logic signed [AMP_W-1:0] amp_re_reg;
    logic signed [AMP_W-1:0] amp_im_reg;

    logic term_vld_reg;
    logic term_fld_reg;
    logic term_neg_reg;

    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SCL_W-1:0]    scaled_reg;
    logic signed [ENERGY_W-1:0] energy_reg;
    logic                       sat_reg;
    logic signed [PRD_W-1:0]    prod_re_reg;
    logic signed [PRD_W-1:0]    prod_im_reg;

    result_t result_reg;
    logic    result_valid_reg;

    mem_ctrl_t mem_ctrl;
    logic signed [COEF_W-1:0] fld_rdata;
    logic signed [COEF_W-1:0] cpl_rdata;

    logic item_acc;
    logic run_last;
    logic clr_last;
    logic result_load;
    logic [CNT_W-1:0] n_eff;
    logic [STATE_W-1:0] bits_i_sh;
    logic [STATE_W-1:0] bits_j_sh;
    logic bit_i;
    logic bit_j;

    ide_coef_mem u_coef_mem (
        .clk       (clk),
        .ctrl      (mem_ctrl),
        .fld_rdata (fld_rdata),
        .cpl_rdata (cpl_rdata)
    );

    assign item_acc = item_valid && item_ready;
    assign run_last = (i_reg == n_last_reg) && (j_reg == n_last_reg);
    assign clr_last = (clr_cnt_reg == CPL_AW'(CPL_DEPTH - 1));
    assign n_eff    = (spins_reg > SPINS_W'(MAX_SPINS)) ? CNT_W'(MAX_SPINS)
                                                        : CNT_W'(spins_reg);

    // Spins at or beyond the state width shift out as clear bits.
    assign bits_i_sh = bits_reg >> i_reg;
    assign bits_j_sh = bits_reg >> j_reg;
    assign bit_i     = bits_i_sh[0];
    assign bit_j     = bits_j_sh[0];

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_acc && item.cmd == CMD_EVAL)
                begin
                    state_next = (n_eff == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (run_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_ENERGY;
            ST_ENERGY: state_next = ST_PROD;
            ST_PROD:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        item_ready         = 1'b0;
        result_load        = 1'b0;
        mem_ctrl.fld_we    = 1'b0;
        mem_ctrl.fld_waddr = item.where_index[SPIN_W-1:0];
        mem_ctrl.cpl_we    = 1'b0;
        mem_ctrl.cpl_waddr = item.where_index[CPL_AW-1:0];
        mem_ctrl.wdata     = item.coeff_value;
        mem_ctrl.fld_raddr = i_reg;
        mem_ctrl.cpl_raddr = CPL_AW'(CPL_AW'(i_reg) * CPL_AW'(MAX_SPINS) + CPL_AW'(j_reg));
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_ctrl.fld_we    = (clr_cnt_reg < CPL_AW'(MAX_SPINS));
                mem_ctrl.fld_waddr = clr_cnt_reg[SPIN_W-1:0];
                mem_ctrl.cpl_we    = 1'b1;
                mem_ctrl.cpl_waddr = clr_cnt_reg;
                mem_ctrl.wdata     = '0;
            end
            ST_IDLE:
            begin
                item_ready      = 1'b1;
                mem_ctrl.fld_we = item_valid && item.cmd == CMD_LOAD_FIELD
                                  && item.where_index < STATE_W'(MAX_SPINS);
                mem_ctrl.cpl_we = item_valid && item.cmd == CMD_LOAD_CPL
                                  && item.where_index < STATE_W'(CPL_DEPTH);
            end
            ST_FINISH:
            begin
                result_load = !result_valid_reg || result_ready;
            end
            ST_RUN, ST_DRAIN, ST_SCALE, ST_ENERGY, ST_PROD:
            begin
                item_ready = 1'b0;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_s_reg <= SCALE_W'(SCALE_RESET);
            spins_reg   <= SPINS_W'(SPINS_RESET);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SCALE_S: scale_s_reg <= cfg_data;
                REG_SPINS:   spins_reg   <= cfg_data[SPINS_W-1:0];
                default:     scale_s_reg <= scale_s_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: clear sweep and term walk
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            term_vld_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            term_vld_reg <= (state_reg == ST_RUN);
            if (item_acc)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            else if (state_reg == ST_RUN && !run_last)
            begin
                // Advance to the next pair, or to the next spin's field term.
                if (j_reg == n_last_reg)
                begin
                    i_reg <= i_reg + 1'b1;
                    j_reg <= i_reg + 1'b1;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] term_coef;
    logic signed [ACC_W-1:0]  term_ext;
    logic signed [SCL_W-1:0]  e_sum;
    logic signed [SCL_W-1:0]  e_rnd;
    logic signed [ENERGY_W-1:0] energy_next;
    logic                     e_sat;
    logic signed [PRD_W-1:0]  re_sum, re_rnd, im_sum, im_rnd;
    logic signed [OUT_W-1:0]  re_next, im_next;
    logic                     re_sat, im_sat;

    localparam logic signed [SCL_W-1:0] E_HI = SCL_W'(2 ** (ENERGY_W - 1) - 1);
    localparam logic signed [SCL_W-1:0] E_LO = SCL_W'(-(2 ** (ENERGY_W - 1)));
    localparam logic signed [PRD_W-1:0] P_HI = 40'sh00_7FFF_FFFF;
    localparam logic signed [PRD_W-1:0] P_LO = 40'shFF_8000_0000;

    always_comb
    begin
        term_coef = term_fld_reg ? fld_rdata : cpl_rdata;
        term_ext  = ACC_W'(term_coef);

        // Round half up, then clip to the energy range.
        e_sum = scaled_reg + SCL_W'(2 ** 14);
        e_rnd = e_sum >>> 15;
        e_sat = 1'b0;
        if (e_rnd > E_HI)
        begin
            energy_next = E_HI[ENERGY_W-1:0];
            e_sat       = 1'b1;
        end
        else if (e_rnd < E_LO)
        begin
            energy_next = E_LO[ENERGY_W-1:0];
            e_sat       = 1'b1;
        end
        else
        begin
            energy_next = e_rnd[ENERGY_W-1:0];
        end

        re_sum = prod_re_reg + PRD_W'(128);
        re_rnd = re_sum >>> 8;
        im_sum = prod_im_reg + PRD_W'(128);
        im_rnd = im_sum >>> 8;
        re_sat = 1'b0;
        im_sat = 1'b0;
        if (re_rnd > P_HI)
        begin
            re_next = P_HI[OUT_W-1:0];
            re_sat  = 1'b1;
        end
        else if (re_rnd < P_LO)
        begin
            re_next = P_LO[OUT_W-1:0];
            re_sat  = 1'b1;
        end
        else
        begin
            re_next = re_rnd[OUT_W-1:0];
        end
        if (im_rnd > P_HI)
        begin
            im_next = P_HI[OUT_W-1:0];
            im_sat  = 1'b1;
        end
        else if (im_rnd < P_LO)
        begin
            im_next = P_LO[OUT_W-1:0];
            im_sat  = 1'b1;
        end
        else
        begin
            im_next = im_rnd[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            bits_reg   <= item.where_index;
            amp_re_reg <= item.amp_re;
            amp_im_reg <= item.amp_im;
            n_last_reg <= SPIN_W'(n_eff - 1'b1);
            acc_reg    <= '0;
        end
        else if (term_vld_reg)
        begin
            acc_reg <= term_neg_reg ? (acc_reg - term_ext) : (acc_reg + term_ext);
        end

        // Field term: +h when set. Pair term: -J when the bits agree.
        term_fld_reg <= (i_reg == j_reg);
        term_neg_reg <= (i_reg == j_reg) ? !bit_i : (bit_i == bit_j);

        if (state_reg == ST_SCALE)
        begin
            scaled_reg <= acc_reg * $signed({1'b0, scale_s_reg});
        end
        if (state_reg == ST_ENERGY)
        begin
            energy_reg <= energy_next;
            sat_reg    <= e_sat;
        end
        if (state_reg == ST_PROD)
        begin
            prod_re_reg <= amp_re_reg * energy_reg;
            prod_im_reg <= amp_im_reg * energy_reg;
        end
        if (result_load)
        begin
            result_reg.state_energy <= energy_reg;
            result_reg.out_re       <= re_next;
            result_reg.out_im       <= im_next;
            result_reg.saturated    <= sat_reg || re_sat || im_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: src/ide_checker.sv
// ----------------------------------------------------------------------------
// ide_checker
// Port-level checks of the Ising diagonal energy scaler, bound to the top.
// ----------------------------------------------------------------------------
module ide_checker
    import ide_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input item_t   item,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // Hold a result word until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result word dropped before it was taken");

    // An evaluate word occupies the block.
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.cmd == CMD_EVAL |=> !item_ready)
        else $error("item taken during an evaluate");

    // Loads and unused commands leave the block ready for the next word.
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.cmd != CMD_EVAL |=> item_ready)
        else $error("ready dropped after a load word");

    // Zero energy gives a zero product.
    a_zero_energy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.state_energy == '0
        |-> result.out_re == '0 && result.out_im == '0)
        else $error("nonzero product from zero energy");

endmodule

bind ising_diagonal_energy_scaler ide_checker u_ide_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
